// ===== design/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// Life grid package
// Shared constants, field widths and request codes for the life grid block.
// ----------------------------------------------------------------------------
package lgs_pkg;

  // Grid size and the address widths that follow from it.
  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 32;
  localparam int COL_AW      = (GRID_WIDTH > 1) ? $clog2(GRID_WIDTH) : 1;
  localparam int ROW_AW      = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;

  // Request field widths, fixed by the stream format.
  localparam int ACTION_W = 2;
  localparam int COLUMN_W = 6;
  localparam int ROW_W    = 5;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  typedef logic [ACTION_W-1:0]    action_t;
  typedef logic [GRID_WIDTH-1:0]  row_word_t;

  // Request codes carried in the action field.
  localparam action_t ACT_WRITE   = 2'd0;
  localparam action_t ACT_ADVANCE = 2'd1;
  localparam action_t ACT_READ    = 2'd2;

endpackage

// ===== design/life_grid_generation_step_top.sv =====
// ----------------------------------------------------------------------------
// Life grid generation step
// A 64 by 32 cell grid under the B3/S23 rule, with cell write, cell read and
// whole-grid advance requests on a stream interface.
// ----------------------------------------------------------------------------
// Every request gives exactly one result. A cell write or read loads its result
// into the output register after the addressed row is read and, for a write,
// written back; an advance sweeps the grid memory row by row, handling one
// whole row of cells per cycle. Unused action codes and addresses outside the
// grid load a zero result without touching the memory. The grid lives in a
// row-wide RAM; a per-row valid flag, cleared by reset, makes every row read
// as dead until it is first written, so no clearing pass is needed and the
// block is ready right after reset. A new request is taken while a finished
// result still waits in the output register.
module life_grid_generation_step_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [1:0] action, [7:2] column, [12:8] row, [13] cell_value, [15:14] zero
  input  logic [lgs_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] cell_alive, [7:1] zero
  output logic [lgs_pkg::OUT_DATA_W-1:0]  out_tdata
);

  import lgs_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_RMW      = 3'd1;
  localparam logic [2:0] S_ADV_FILL = 3'd2;
  localparam logic [2:0] S_ADV_ROW  = 3'd3;
  localparam logic [2:0] S_DONE     = 3'd4;

  localparam logic [ROW_AW-1:0] LAST_ROW = ROW_AW'(GRID_HEIGHT - 1);

  // Request fields.
  action_t             in_action;
  logic [COLUMN_W-1:0] in_column;
  logic [ROW_W-1:0]    in_row;
  logic                in_value;
  logic                in_inside;
  logic                accept;

  assign in_action = in_tdata[1:0];
  assign in_column = in_tdata[7:2];
  assign in_row    = in_tdata[12:8];
  assign in_value  = in_tdata[13];
  assign in_inside = (int'(in_column) < GRID_WIDTH) && (int'(in_row) < GRID_HEIGHT);

  // Control and held request state.
  logic [2:0]              state_r, state_nxt;
  action_t                 act_r, act_nxt;
  logic [COL_AW-1:0]       col_r, col_nxt;
  logic                    val_r, val_nxt;
  logic [ROW_AW-1:0]       rd_row_r, rd_row_nxt;
  logic [ROW_AW-1:0]       cur_row_r, cur_row_nxt;
  logic [GRID_HEIGHT-1:0]  row_vld_r, row_vld_nxt;
  logic                    res_r, res_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_data_r, out_data_nxt;

  // Line buffers for the generation sweep: old row above and old current row.
  row_word_t above_r, above_nxt;
  row_word_t mid_r, mid_nxt;

  // Grid memory ports.
  logic              ram_we;
  logic [ROW_AW-1:0] ram_waddr;
  row_word_t         ram_wdata;
  logic [ROW_AW-1:0] ram_raddr;
  row_word_t         ram_rdata;

  lgs_ram #(
    .WIDTH (GRID_WIDTH),
    .DEPTH (GRID_HEIGHT)
  ) u_grid_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // A row never written since reset holds dead cells.
  row_word_t row_word;
  assign row_word = row_vld_r[rd_row_r] ? ram_rdata : '0;

  // Row below the one being updated; dead past the bottom edge.
  row_word_t below;
  assign below = (cur_row_r == LAST_ROW) ? '0 : row_word;

  // Next generation of one row from three old rows, all columns at once.
  row_word_t new_row;
  always_comb begin
    logic [GRID_WIDTH+1:0] pa;
    logic [GRID_WIDTH+1:0] pm;
    logic [GRID_WIDTH+1:0] pb;
    logic [3:0]            n;
    pa = {1'b0, above_r, 1'b0};
    pm = {1'b0, mid_r, 1'b0};
    pb = {1'b0, below, 1'b0};
    for (int c = 0; c < GRID_WIDTH; c++) begin
      n = 4'(pa[c]) + 4'(pa[c+1]) + 4'(pa[c+2])
        + 4'(pm[c]) + 4'(pm[c+2])
        + 4'(pb[c]) + 4'(pb[c+1]) + 4'(pb[c+2]);
      new_row[c] = (n == 4'd3) || (pm[c+1] && (n == 4'd2));
    end
  end

  // Read address two rows ahead of the one being written; row 0 past the end.
  logic [ROW_AW:0]   ahead_wide;
  logic [ROW_AW-1:0] ahead_row;
  assign ahead_wide = {1'b0, cur_row_r} + (ROW_AW+1)'(2);
  assign ahead_row  = (int'(ahead_wide) < GRID_HEIGHT) ? ahead_wide[ROW_AW-1:0] : '0;

  // The output register is free when empty or being emptied this cycle.
  logic out_free;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt   = state_r;
    act_nxt     = act_r;
    col_nxt     = col_r;
    val_nxt     = val_r;
    rd_row_nxt  = rd_row_r;
    cur_row_nxt = cur_row_r;
    row_vld_nxt = row_vld_r;
    res_nxt     = res_r;
    above_nxt   = above_r;
    mid_nxt     = mid_r;
    ram_we      = 1'b0;
    ram_waddr   = cur_row_r;
    ram_wdata   = new_row;
    ram_raddr   = rd_row_r;

    case (state_r)
      S_IDLE: begin
        ram_raddr = in_row[ROW_AW-1:0];
        if (accept) begin
          act_nxt    = in_action;
          col_nxt    = in_column[COL_AW-1:0];
          val_nxt    = in_value;
          res_nxt    = 1'b0;
          if (in_action == ACT_ADVANCE) begin
            ram_raddr  = '0;
            rd_row_nxt = '0;
            state_nxt  = S_ADV_FILL;
          end else if ((in_action == ACT_WRITE || in_action == ACT_READ) && in_inside) begin
            rd_row_nxt = in_row[ROW_AW-1:0];
            state_nxt  = S_RMW;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end

      S_RMW: begin
        // Row data of the addressed cell is on the RAM output now.
        if (act_r == ACT_WRITE) begin
          ram_we               = 1'b1;
          ram_waddr            = rd_row_r;
          ram_wdata            = row_word;
          ram_wdata[col_r]     = val_r;
          row_vld_nxt[rd_row_r] = 1'b1;
          res_nxt              = 1'b0;
        end else begin
          res_nxt = row_word[col_r];
        end
        state_nxt = S_DONE;
      end

      S_ADV_FILL: begin
        // Row 0 is on the RAM output; fetch row 1.
        above_nxt   = '0;
        mid_nxt     = row_word;
        cur_row_nxt = '0;
        ram_raddr   = ROW_AW'(1);
        rd_row_nxt  = ROW_AW'(1);
        state_nxt   = S_ADV_ROW;
      end

      S_ADV_ROW: begin
        // Old rows above and current are held; the row below is on the RAM
        // output. The current row is written in place, since it is never read
        // again in this sweep.
        ram_we                 = 1'b1;
        ram_waddr              = cur_row_r;
        ram_wdata              = new_row;
        row_vld_nxt[cur_row_r] = 1'b1;
        above_nxt              = mid_r;
        mid_nxt                = below;
        ram_raddr              = ahead_row;
        rd_row_nxt             = ahead_row;
        if (cur_row_r == LAST_ROW) begin
          res_nxt   = 1'b0;
          state_nxt = S_DONE;
        end else begin
          cur_row_nxt = cur_row_r + ROW_AW'(1);
        end
      end

      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_DONE && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_vld_r   <= row_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r     <= act_nxt;
    col_r     <= col_nxt;
    val_r     <= val_nxt;
    rd_row_r  <= rd_row_nxt;
    cur_row_r <= cur_row_nxt;
    res_r     <= res_nxt;
    above_r   <= above_nxt;
    mid_r     <= mid_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W-1)'(0), out_data_r};

endmodule

// ===== design/lgs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module lgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/lgs_checker.sv =====
// ----------------------------------------------------------------------------
// Life grid port checker
// Concurrent checks on the life grid block's ports, bound to the top level.
// ----------------------------------------------------------------------------
module lgs_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [lgs_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [lgs_pkg::OUT_DATA_W-1:0]  out_tdata
);

  import lgs_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Only the cell bit of a result may be set.
  a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_DATA_W-1:1] == '0)
    else $error("result padding not zero");

  // Reset empties the output register.
  a_out_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // One request at a time: the block is busy right after taking one.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while busy");

  // An advance taken while the output is empty is not followed at once by a live result.
  a_adv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tdata[1:0] == ACT_ADVANCE) && !out_tvalid
    |=> !(out_tvalid && out_tdata[0]))
    else $error("advance gave a live result");

endmodule

bind life_grid_generation_step_top lgs_checker u_lgs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== sim/life_grid_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Life grid checker
// Watches both stream channels of the life grid block, keeps its own copy of
// the cell grid, predicts the cell_alive of every result and compares.
// ----------------------------------------------------------------------------
module life_grid_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [lgs_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [lgs_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                             mismatches,
  output int                             outstanding
);

  import lgs_pkg::*;

  localparam int BIRTH_COUNT  = 3;
  localparam int SURVIVE_LOW  = 2;
  localparam int SURVIVE_HIGH = 3;

  row_word_t grid_rows [GRID_HEIGHT];
  bit        alive_q [$];

  action_t             req_action;
  logic [COLUMN_W-1:0] req_column;
  logic [ROW_W-1:0]    req_row;
  logic                req_value;
  bit                  predicted;
  bit                  want;

  task automatic report_mismatch(input string what, input logic got, input logic exp_val);
    $display("%0t ns: mismatch, %s: cell_alive %b, expected %b", $time, what, got, exp_val);
    mismatches++;
  endtask

  function automatic bit cell_at(input int col, input int row);
    if (col < 0 || row < 0 || col >= GRID_WIDTH || row >= GRID_HEIGHT) return 1'b0;
    return grid_rows[row][col];
  endfunction

  // Every cell of the new generation comes from the old grid only.
  function automatic void step_generation();
    row_word_t nxt [GRID_HEIGHT];
    int        n;
    for (int r = 0; r < GRID_HEIGHT; r++) begin
      for (int c = 0; c < GRID_WIDTH; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++)
          for (int dc = -1; dc <= 1; dc++)
            if (dr != 0 || dc != 0) n += cell_at(c + dc, r + dr);
        if (grid_rows[r][c]) nxt[r][c] = (n >= SURVIVE_LOW && n <= SURVIVE_HIGH);
        else nxt[r][c] = (n == BIRTH_COUNT);
      end
    end
    grid_rows = nxt;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      // Reset leaves every cell dead and nothing in flight.
      foreach (grid_rows[r]) grid_rows[r] = '0;
      alive_q.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (alive_q.size() == 0) begin
          report_mismatch("result with no request waiting", out_tdata[0], 1'b0);
        end else begin
          want = alive_q.pop_front();
          if (out_tdata[0] !== want) report_mismatch("wrong cell_alive", out_tdata[0], want);
        end
      end
      if (in_tvalid && in_tready) begin
        req_action = in_tdata[ACTION_W-1:0];
        req_column = in_tdata[ACTION_W +: COLUMN_W];
        req_row    = in_tdata[ACTION_W+COLUMN_W +: ROW_W];
        req_value  = in_tdata[ACTION_W+COLUMN_W+ROW_W];
        predicted  = 1'b0;
        case (req_action)
          ACT_WRITE: begin
            if (req_column < GRID_WIDTH && req_row < GRID_HEIGHT)
              grid_rows[req_row][req_column] = req_value;
          end
          ACT_ADVANCE: begin
            step_generation();
          end
          ACT_READ: begin
            predicted = cell_at(req_column, req_row);
          end
          default: begin
          end
        endcase
        alive_q.push_back(predicted);
      end
      outstanding = alive_q.size();
    end
  end

endmodule

// ===== sim/life_grid_generation_step_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Life grid generation step testbench
// Drives cell writes, cell reads, generation steps and unused codes into the
// life grid block with random idling on both channels; a checker beside the
// block predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module life_grid_generation_step_top_test;
  import lgs_pkg::*;

  // The one action code that the block leaves unused.
  localparam action_t ACT_UNUSED = 2'd3;

  // Number of counted requests after which the random part stops.
  localparam int TOTAL_REQUESTS = 290;

  // An advance is the slowest request: it sweeps every row of the grid.
  localparam int SETTLE_CYCLES = GRID_HEIGHT + 8;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;

  int mismatches;
  int outstanding;

  // Requests sent that the block does act upon; unused codes are not counted.
  int  sent;
  // When set, the sender puts no gaps between requests.
  bit  tx_quiet;
  // When set, the receiver never stalls.
  bit  rx_quiet;

  life_grid_generation_step_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  life_grid_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs. The slowest correct run is far below
  // this: every request waiting out the longest gap, the advance sweep and
  // the longest receiver stall still stays within a few hundred microseconds.
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Sends one request. It is called at a falling edge and returns at the
  // falling edge after the request was taken, with in_tvalid still high, so
  // that back-to-back requests never lower and raise valid in one time step.
  task automatic send_request(input action_t act, input int col, input int row,
                              input bit val);
    int                  gap;
    logic [COLUMN_W-1:0] col_f;
    logic [ROW_W-1:0]    row_f;
    col_f = col[COLUMN_W-1:0];
    row_f = row[ROW_W-1:0];
    gap   = tx_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  <= {2'b00, val, row_f, col_f, act};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    if (act != ACT_UNUSED) sent++;
  endtask

  // Any code, any address, any value: noise between the structured requests.
  task automatic send_noise();
    send_request(action_t'($urandom_range(0, 3)), $urandom_range(0, 63),
                 $urandom_range(0, 31), 1'($urandom_range(0, 1)));
  endtask

  // Holds the sender until the block has answered every request so far.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // Origin of an 8 by 8 window, biased towards both edges of the grid so that
  // the missing neighbors beyond the border are exercised often.
  function automatic int pick_origin(input int extent);
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return extent - 8;
      default: return $urandom_range(0, extent - 8);
    endcase
  endfunction

  // Receiver: draws a stall for every result, with stretches of no stalling.
  initial begin
    int stall;
    out_tready = 1'b0;
    rx_quiet   = 1'b0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) rx_quiet = !rx_quiet;
      stall = rx_quiet ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // Stimulus and verdict.
  initial begin
    int c0;
    int r0;
    int burst;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    sent      = 0;
    tx_quiet  = 1'b0;
    burst     = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. A cell never written must read as dead after reset.
    send_request(ACT_READ,    0,  0, 1'b0);
    // All four corners alive, then two of them read back; cell_value is ignored on a read.
    send_request(ACT_WRITE,   0,  0, 1'b1);
    send_request(ACT_WRITE,  63, 31, 1'b1);
    send_request(ACT_WRITE,  63,  0, 1'b1);
    send_request(ACT_WRITE,   0, 31, 1'b1);
    send_request(ACT_READ,   63, 31, 1'b1);
    send_request(ACT_READ,    0,  0, 1'b0);
    // The unused code must change nothing, even with every field set.
    send_request(ACT_UNUSED, 63, 31, 1'b1);
    send_request(ACT_READ,   63, 31, 1'b0);
    // Writing a dead value clears a cell.
    send_request(ACT_WRITE,   0,  0, 1'b0);
    send_request(ACT_READ,    0,  0, 1'b1);
    // A blinker lying along the top edge and one along the left edge: their
    // neighbors beyond the border must count as dead.
    send_request(ACT_WRITE,  30,  0, 1'b1);
    send_request(ACT_WRITE,  31,  0, 1'b1);
    send_request(ACT_WRITE,  32,  0, 1'b1);
    send_request(ACT_WRITE,   0, 10, 1'b1);
    send_request(ACT_WRITE,   0, 11, 1'b1);
    send_request(ACT_WRITE,   0, 12, 1'b1);
    // Address and value fields are ignored during an advance.
    send_request(ACT_ADVANCE, 63, 31, 1'b1);
    send_request(ACT_READ,   31,  1, 1'b0);
    send_request(ACT_READ,   30,  0, 1'b0);
    send_request(ACT_READ,    1, 11, 1'b0);
    send_request(ACT_ADVANCE, 0,  0, 1'b0);
    send_request(ACT_READ,   31,  0, 1'b0);
    // Alternating bit patterns in the address fields.
    send_request(ACT_WRITE,  42, 21, 1'b1);
    send_request(ACT_READ,   42, 21, 1'b0);

    // Let the block run dry once before the random part starts.
    drain_results();

    // Random part: each burst seeds a dense window with live cells, then
    // steps the grid a few times and reads cells back from that window.
    // Earlier bursts stay in the grid, so later steps act on a crowded board.
    while (sent < TOTAL_REQUESTS) begin
      tx_quiet = ($urandom_range(0, 3) == 0);
      c0 = pick_origin(GRID_WIDTH);
      r0 = pick_origin(GRID_HEIGHT);
      repeat ($urandom_range(12, 24)) begin
        if ($urandom_range(0, 9) == 0) begin
          send_noise();
        end else begin
          send_request(ACT_WRITE, c0 + $urandom_range(0, 7), r0 + $urandom_range(0, 7),
                       $urandom_range(0, 2) != 0);
        end
      end
      repeat ($urandom_range(2, 4)) begin
        send_request(ACT_ADVANCE, $urandom_range(0, 63), $urandom_range(0, 31),
                     1'($urandom_range(0, 1)));
        repeat ($urandom_range(2, 5)) begin
          if ($urandom_range(0, 7) == 0) begin
            send_noise();
          end else begin
            send_request(ACT_READ, c0 + $urandom_range(0, 7), r0 + $urandom_range(0, 7),
                         1'($urandom_range(0, 1)));
          end
        end
      end
      burst++;
      if (burst % 5 == 0) drain_results();
    end

    // Wait for every outstanding result, then give the block time to show
    // any result that nobody asked for.
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
